// ===== rtl/core/lzsw_pkg.sv =====
// shared types and constants of the lzss window decoder
package lzsw_pkg;

   localparam int WINDOW_DEPTH_DEFAULT = 4096;
   localparam int MIN_MATCH            = 3;
   localparam int MAX_MATCH            = 18;
   localparam int MATCH_LEN_W          = 5;
   localparam int CMD_DEPTH            = 4;
   localparam int RSP_DEPTH            = 4;
   localparam logic [7:0] SPACE_BYTE   = 8'h20;
   localparam logic [7:0] LEN_MASK     = 8'h0F;
   localparam logic [7:0] POS_HI_MASK  = 8'hF0;

   localparam logic CSR_SIZE_KNOWN    = 1'b0;
   localparam logic CSR_EXPECTED_SIZE = 1'b1;

   typedef enum logic [1:0] {
      ST_DECODING = 2'd0,
      ST_DONE     = 2'd1,
      ST_TRUNC    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      PH_FLAG  = 2'd0,
      PH_TOKEN = 2'd1,
      PH_HIGH  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_LIT   = 2'd1,
      CMD_MATCH = 2'd2,
      CMD_END   = 2'd3
   } cmd_kind_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_COPY = 1'b1
   } back_state_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       last_of_run;
      status_type status;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   lo;
      logic [7:0]   hi;
      logic         in_token;
   } cmd_type;

   typedef struct packed {
      logic        size_known;
      logic [31:0] expected_size;
   } cfg_type;

endpackage

// ===== rtl/core/lzsw_fifo.sv =====
// small flop-based queue between front and back, and for results
module lzsw_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             push_data,
   output logic                         full,
   input  logic                         pop,
   output logic [WIDTH-1:0]             pop_data,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   level
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign level    = count_ff;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/lzsw_front.sv =====
// front end: parses flag bytes and tokens into back-end commands
module lzsw_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  lzsw_pkg::req_type req_data,
   input  logic              cmd_full,
   output logic              cmd_push,
   output lzsw_pkg::cmd_type cmd_data
);
   import lzsw_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] flags_ff, flags_in;
   logic [2:0] idx_ff, idx_in;
   logic [7:0] held_ff, held_in;
   logic       accept;
   logic       lit;
   logic [7:0] b;

   assign accept = req_push && !cmd_full;
   assign b      = req_data.in_byte;
   assign lit    = flags_ff[idx_ff];

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (accept && !req_data.end_of_input) begin
         unique case (phase_ff)
            PH_TOKEN: begin
               if (lit) begin
                  phase_in = (idx_ff == 3'd7) ? PH_FLAG : PH_TOKEN;
               end else begin
                  phase_in = PH_HIGH;
               end
            end
            PH_HIGH: begin
               phase_in = (idx_ff == 3'd0) ? PH_FLAG : PH_TOKEN;
            end
            default: begin
               phase_in = PH_TOKEN;
            end
         endcase
      end
   end

   // command and token bookkeeping
   always_comb begin
      flags_in          = flags_ff;
      idx_in            = idx_ff;
      held_in           = held_ff;
      cmd_push          = accept;
      cmd_data.kind     = CMD_NONE;
      cmd_data.lo       = b;
      cmd_data.hi       = b;
      cmd_data.in_token = (phase_ff == PH_TOKEN) || (phase_ff == PH_HIGH);
      if (req_data.end_of_input) begin
         cmd_data.kind = CMD_END;
      end else begin
         unique case (phase_ff)
            PH_TOKEN: begin
               idx_in = idx_ff + 1'b1;
               if (lit) begin
                  cmd_data.kind = CMD_LIT;
               end else if (accept) begin
                  held_in = b;
               end
            end
            PH_HIGH: begin
               cmd_data.kind = CMD_MATCH;
               cmd_data.lo   = held_ff;
            end
            default: begin
               flags_in = b;
               idx_in   = 3'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FLAG;
         flags_ff <= '0;
         idx_ff   <= '0;
         held_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         if (accept) begin
            flags_ff <= flags_in;
            idx_ff   <= idx_in;
            held_ff  <= held_in;
         end
      end
   end

endmodule

// ===== rtl/core/lzsw_back.sv =====
// back end: size checks, window copy and result generation
module lzsw_back #(
   parameter int WINDOW_DEPTH = lzsw_pkg::WINDOW_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lzsw_pkg::cfg_type                   cfg,
   input  logic                                cmd_empty,
   input  lzsw_pkg::cmd_type                   cmd_data,
   output logic                                cmd_pop,
   input  logic [$clog2(lzsw_pkg::RSP_DEPTH+1)-1:0] rsp_level,
   output logic                                rsp_push,
   output lzsw_pkg::rsp_type                   rsp_wdata
);
   import lzsw_pkg::*;

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam int LW = $clog2(RSP_DEPTH+1);
   localparam logic [AW-1:0] WP_RESET = AW'(WINDOW_DEPTH - MAX_MATCH);

   back_state_type          state_ff, state_in;
   logic [31:0]             count_ff, count_in;
   logic                    finished_ff, finished_in;
   logic [AW-1:0]           addr_ff, addr_in;
   logic [MATCH_LEN_W-1:0]  left_ff, left_in;
   logic                    cut_ff, cut_in;

   logic                    iss_valid, iss_copy, iss_bvalid, iss_last;
   logic [7:0]              iss_byte;
   status_type              iss_status;
   logic [AW-1:0]           iss_addr;

   logic                    s1_valid_ff, s1_copy_ff, s1_fwd_ff, s1_hit_ff;
   logic                    s1_bvalid_ff, s1_last_ff;
   logic [7:0]              s1_byte_ff;
   status_type              s1_status_ff;

   logic [AW-1:0]           wp_ff;
   logic [AW:0]             fill_ff;
   logic [7:0]              q_ff;
   logic [7:0]              win_mem [WINDOW_DEPTH];

   logic                    space, reached, cut, fwd, hit, win_we;
   logic [31:0]             rem;
   logic [MATCH_LEN_W-1:0]  mlen;
   logic [AW-1:0]           mpos, roff;
   logic [7:0]              w_byte;

   // room for the issued result plus the one in the write stage
   assign space   = ({1'b0, rsp_level} + {{LW{1'b0}}, s1_valid_ff}) < (LW+1)'(RSP_DEPTH);
   assign reached = cfg.size_known && (count_ff >= cfg.expected_size);
   assign rem     = cfg.expected_size - count_ff;
   assign mlen    = {1'b0, cmd_data.hi[3:0] & LEN_MASK[3:0]} + MATCH_LEN_W'(MIN_MATCH);
   assign mpos    = AW'({cmd_data.hi[7:4] & POS_HI_MASK[7:4], cmd_data.lo});
   assign cut     = cfg.size_known && (rem <= 32'(mlen));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (space && !cmd_empty && !finished_ff && !reached &&
                cmd_data.kind == CMD_MATCH) begin
               state_in = BK_COPY;
            end
         end
         BK_COPY: begin
            if (space && left_ff == MATCH_LEN_W'(1)) begin
               state_in = BK_IDLE;
            end
         end
      endcase
   end

   // issue side
   always_comb begin
      cmd_pop     = 1'b0;
      iss_valid   = 1'b0;
      iss_copy    = 1'b0;
      iss_bvalid  = 1'b0;
      iss_last    = 1'b0;
      iss_byte    = '0;
      iss_status  = ST_DECODING;
      iss_addr    = addr_ff;
      count_in    = count_ff;
      finished_in = finished_ff;
      addr_in     = addr_ff;
      left_in     = left_ff;
      cut_in      = cut_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (space && !cmd_empty) begin
               cmd_pop = 1'b1;
               priority if (finished_ff) begin
                  cmd_pop = 1'b1;
               end else if (reached) begin
                  iss_valid   = 1'b1;
                  iss_last    = 1'b1;
                  iss_status  = ST_DONE;
                  finished_in = 1'b1;
               end else begin
                  unique case (cmd_data.kind)
                     CMD_LIT: begin
                        iss_valid  = 1'b1;
                        iss_bvalid = 1'b1;
                        iss_last   = 1'b1;
                        iss_byte   = cmd_data.lo;
                        count_in   = count_ff + 1'b1;
                        if (cfg.size_known && rem == 32'd1) begin
                           iss_status  = ST_DONE;
                           finished_in = 1'b1;
                        end
                     end
                     CMD_MATCH: begin
                        addr_in = mpos;
                        left_in = cut ? rem[MATCH_LEN_W-1:0] : mlen;
                        cut_in  = cut;
                     end
                     CMD_END: begin
                        iss_valid   = 1'b1;
                        iss_last    = 1'b1;
                        iss_status  = (cmd_data.in_token || cfg.size_known) ?
                                      ST_TRUNC : ST_DONE;
                        finished_in = 1'b1;
                     end
                     default: begin
                        iss_valid = 1'b0;
                     end
                  endcase
               end
            end
         end
         BK_COPY: begin
            if (space) begin
               iss_valid  = 1'b1;
               iss_copy   = 1'b1;
               iss_bvalid = 1'b1;
               count_in   = count_ff + 1'b1;
               addr_in    = addr_ff + 1'b1;
               left_in    = left_ff - 1'b1;
               if (left_ff == MATCH_LEN_W'(1)) begin
                  iss_last = 1'b1;
                  if (cut_ff) begin
                     iss_status  = ST_DONE;
                     finished_in = 1'b1;
                  end
               end
            end
         end
      endcase
   end

   // write stage: resolve the byte, write it back, hand it on
   assign w_byte = (s1_copy_ff && !s1_fwd_ff) ? (s1_hit_ff ? q_ff : SPACE_BYTE)
                                              : s1_byte_ff;
   assign win_we = s1_valid_ff && s1_bvalid_ff;

   // read of the entry being written this cycle takes the new byte
   assign fwd  = win_we && (iss_addr == wp_ff);
   // entries are filled in order from the reset pointer on
   assign roff = iss_addr - WP_RESET;
   assign hit  = {1'b0, roff} < fill_ff;

   assign rsp_push              = s1_valid_ff;
   assign rsp_wdata.out_byte    = s1_bvalid_ff ? w_byte : 8'd0;
   assign rsp_wdata.byte_valid  = s1_bvalid_ff;
   assign rsp_wdata.last_of_run = s1_last_ff;
   assign rsp_wdata.status      = s1_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_IDLE;
         count_ff    <= '0;
         finished_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         wp_ff       <= WP_RESET;
         fill_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         finished_ff <= finished_in;
         s1_valid_ff <= iss_valid;
         if (win_we) begin
            wp_ff <= wp_ff + 1'b1;
            if (fill_ff != (AW+1)'(WINDOW_DEPTH)) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      left_ff      <= left_in;
      cut_ff       <= cut_in;
      s1_copy_ff   <= iss_copy;
      s1_fwd_ff    <= fwd;
      s1_hit_ff    <= hit;
      s1_bvalid_ff <= iss_bvalid;
      s1_last_ff   <= iss_last;
      s1_status_ff <= iss_status;
      s1_byte_ff   <= (iss_copy && fwd) ? w_byte : iss_byte;
   end

   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[wp_ff] <= w_byte;
      end
      q_ff <= win_mem[iss_addr];
   end

`ifndef SYNTHESIS
   a_rsp_room: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (rsp_level < LW'(RSP_DEPTH)))
      else $error("result beat pushed into a full queue");
   a_quiet_after_finish: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> !iss_valid)
      else $error("result issued after decoding finished");
   a_copy_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_COPY) |-> (left_ff != '0))
      else $error("copy running with no bytes left");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= (AW+1)'(WINDOW_DEPTH))
      else $error("window fill count overran depth");
   a_wp_step: assert property (@(posedge clock) disable iff (reset)
      win_we |=> (wp_ff == AW'($past(wp_ff) + 1'b1)))
      else $error("write pointer did not advance after a byte");
`endif

endmodule

// ===== rtl/core/lzss_window_decoder.sv =====
// top level of the lzss window decoder: csr registers, front, queues, back
//
//  channel  direction  handshake              beat
//  req      in         push / full            req_type: in_byte, end_of_input
//  rsp      out        pop / empty            rsp_type: out_byte, byte_valid,
//                                                       last_of_run, status
//  csr      in         csr_we                 csr_index, csr_wdata (32 bits)
//
// the front takes one beat per cycle while its command queue has room.
// the back issues a literal or status beat from idle and a match's bytes in the
// copy state; a result passes the write stage register and the result queue
// before it shows on rsp. reset is synchronous; window entries not yet written
// read as spaces by the fill count, so no clearing pass is needed. a stalled rsp
// side backs up the result queue, then the back, the command queue and req_full.
module lzss_window_decoder #(
   parameter int WINDOW_DEPTH = lzsw_pkg::WINDOW_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  lzsw_pkg::req_type req_data,
   output logic              req_full,
   input  logic              rsp_pop,
   output lzsw_pkg::rsp_type rsp_data,
   output logic              rsp_empty,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata
);
   import lzsw_pkg::*;

   localparam int RLW = $clog2(RSP_DEPTH+1);

   cfg_type        cfg_ff;
   cmd_type        front_cmd, back_cmd;
   logic           front_push, cmd_full, cmd_empty, cmd_pop;
   rsp_type        back_rsp;
   logic           back_push;
   logic [RLW-1:0] rsp_level;
   logic           rsp_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         if (csr_index == CSR_SIZE_KNOWN) begin
            cfg_ff.size_known <= csr_wdata[0];
         end else begin
            cfg_ff.expected_size <= csr_wdata;
         end
      end
   end

   assign req_full = cmd_full;

   lzsw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .cmd_full (cmd_full),
      .cmd_push (front_push),
      .cmd_data (front_cmd)
   );

   lzsw_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_cmd),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (back_cmd),
      .empty     (cmd_empty),
      .level     ()
   );

   lzsw_back #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_empty (cmd_empty),
      .cmd_data  (back_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_level (rsp_level),
      .rsp_push  (back_push),
      .rsp_wdata (back_rsp)
   );

   lzsw_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (back_rsp),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty),
      .level     (rsp_level)
   );

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      back_push |-> !rsp_full)
      else $error("result queue overflow");
   a_cmd_order: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("command taken from an empty queue");
   a_front_gate: assert property (@(posedge clock) disable iff (reset)
      front_push |-> !cmd_full)
      else $error("command pushed into a full queue");
`endif

endmodule

// ===== bench/tb.sv =====
// testbench for the lzss window decoder: random token streams against a built-in decoder model
`timescale 1ns / 1ps

module tb;
   import lzsw_pkg::*;

   localparam int WINDOW        = WINDOW_DEPTH_DEFAULT;
   localparam int SETTLE_CYCLES = 48;
   localparam int LONG_HOLD     = 400;
   localparam int QUIET_LIMIT   = 4000;

   // decoder model plus the queue of decoded bytes still owed by the block
   class decode_scoreboard;
      bit [7:0]    window [WINDOW];
      bit [11:0]   wr_ptr;
      bit [7:0]    flags;
      bit [2:0]    flag_idx;
      phase_type   phase;
      bit [7:0]    lo_pos;
      bit [31:0]   produced;
      bit          done;
      bit          size_known;
      bit [31:0]   size_limit;
      rsp_type     owed [$];
      int          fails;
      int          seen;

      function new();
         foreach (window[i]) window[i] = SPACE_BYTE;
         wr_ptr     = 12'(WINDOW - MAX_MATCH);
         flags      = '0;
         flag_idx   = '0;
         phase      = PH_FLAG;
         lo_pos     = '0;
         produced   = '0;
         done       = 1'b0;
         size_known = 1'b0;
         size_limit = '0;
         fails      = 0;
         seen       = 0;
      endfunction

      function void set_reg(logic idx, logic [31:0] value);
         if (idx == CSR_SIZE_KNOWN) size_known = value[0];
         else size_limit = value;
      endfunction

      function bit size_met();
         return size_known && produced >= size_limit;
      endfunction

      function rsp_type make_result(logic [7:0] b, logic valid, logic last, status_type st);
         rsp_type r;
         r.out_byte    = b;
         r.byte_valid  = valid;
         r.last_of_run = last;
         r.status      = st;
         return r;
      endfunction

      // write one decoded byte to the history and owe it on rsp
      function bit put_byte(logic [7:0] b);
         bit hit;
         window[wr_ptr] = b;
         wr_ptr   = wr_ptr + 12'd1;
         produced = produced + 32'd1;
         hit      = size_met();
         owed.push_back(make_result(b, 1'b1, 1'b0, hit ? ST_DONE : ST_DECODING));
         return hit;
      endfunction

      function void decode_beat(req_type beat);
         logic       lit;
         logic [11:0] pos;
         int         len;
         status_type st;
         if (done) return;
         if (size_met()) begin
            done = 1'b1;
            owed.push_back(make_result(8'h00, 1'b0, 1'b1, ST_DONE));
            return;
         end
         if (beat.end_of_input) begin
            if (phase == PH_TOKEN || phase == PH_HIGH) st = ST_TRUNC;
            else st = size_known ? ST_TRUNC : ST_DONE;
            done = 1'b1;
            owed.push_back(make_result(8'h00, 1'b0, 1'b1, st));
            return;
         end
         case (phase)
            PH_TOKEN: begin
               lit      = flags[flag_idx];
               flag_idx = flag_idx + 3'd1;
               if (lit) begin
                  if (put_byte(beat.in_byte)) done = 1'b1;
                  owed[owed.size() - 1].last_of_run = 1'b1;
                  phase = (flag_idx == 3'd0) ? PH_FLAG : PH_TOKEN;
               end else begin
                  lo_pos = beat.in_byte;
                  phase  = PH_HIGH;
               end
            end
            PH_HIGH: begin
               pos   = {beat.in_byte[7:4], lo_pos};
               len   = int'(beat.in_byte & LEN_MASK) + MIN_MATCH;
               phase = (flag_idx == 3'd0) ? PH_FLAG : PH_TOKEN;
               // copy reads the live window, so an overlapping source sees fresh bytes
               for (int i = 0; i < len; i++) begin
                  if (put_byte(window[pos + 12'(i)])) begin
                     done = 1'b1;
                     break;
                  end
               end
               owed[owed.size() - 1].last_of_run = 1'b1;
            end
            default: begin
               flags    = beat.in_byte;
               flag_idx = 3'd0;
               phase    = PH_TOKEN;
            end
         endcase
      endfunction

      task report_mismatch(string what);
         $display("mismatch at rsp beat %0d: %s", seen, what);
         fails++;
      endtask

      task compare_result(rsp_type got);
         rsp_type want;
         if (owed.size() == 0) begin
            report_mismatch($sformatf("unexpected beat %h", got));
         end else begin
            want = owed.pop_front();
            if (got.out_byte !== want.out_byte)
               report_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
            if (got.byte_valid !== want.byte_valid)
               report_mismatch($sformatf("byte_valid %b, want %b",
                                         got.byte_valid, want.byte_valid));
            if (got.last_of_run !== want.last_of_run)
               report_mismatch($sformatf("last_of_run %b, want %b",
                                         got.last_of_run, want.last_of_run));
            if (got.status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
         end
         seen++;
      endtask
   endclass

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_push  = 1'b0;
   req_type     req_data  = '0;
   logic        req_full;
   logic        rsp_pop   = 1'b0;
   rsp_type     rsp_data;
   logic        rsp_empty;
   logic        csr_we    = 1'b0;
   logic        csr_index = CSR_SIZE_KNOWN;
   logic [31:0] csr_wdata = '0;

   decode_scoreboard sb = new();
   bit          calm         = 1'b0;
   bit          hold_request = 1'b0;
   int unsigned items_sent   = 0;

   lzss_window_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic req_type make_beat(logic [7:0] b, logic eoi);
      req_type beat;
      beat.in_byte      = b;
      beat.end_of_input = eoi;
      return beat;
   endfunction

   // push stays high after a beat unless an idle burst follows
   task automatic push_beat(input req_type beat);
      req_push <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (req_full);
      if (!sb.done) items_sent++;
      sb.decode_beat(beat);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic send_match(input logic [11:0] pos, input logic [3:0] len_code);
      push_beat(make_beat(pos[7:0], 1'b0));
      push_beat(make_beat({pos[11:8], len_code}, 1'b0));
   endtask

   // one flag beat and its eight tokens, random literals and copies, the copies mostly from recent history
   task automatic send_group();
      logic [7:0]  flag;
      logic [11:0] pos;
      flag = 8'($urandom_range(0, 255));
      push_beat(make_beat(flag, 1'b0));
      for (int k = 0; k < 8; k++) begin
         if (flag[k]) begin
            push_beat(make_beat(8'($urandom_range(0, 255)), 1'b0));
         end else begin
            if ($urandom_range(0, 9) < 7) pos = sb.wr_ptr - 12'($urandom_range(1, 40));
            else pos = 12'($urandom_range(0, WINDOW - 1));
            send_match(pos, 4'($urandom_range(0, 15)));
         end
      end
   endtask

   // stop sending, wait for every owed beat, then let beats with no output clear
   task automatic drain_block();
      req_push <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic sk, input logic [31:0] limit);
      csr_we    <= 1'b1;
      csr_index <= CSR_SIZE_KNOWN;
      csr_wdata <= {31'd0, sk};
      @(posedge clock);
      sb.set_reg(CSR_SIZE_KNOWN, {31'd0, sk});
      csr_index <= CSR_EXPECTED_SIZE;
      csr_wdata <= limit;
      @(posedge clock);
      sb.set_reg(CSR_EXPECTED_SIZE, limit);
      csr_we <= 1'b0;
   endtask

   // result side: random idle bursts, and one long hold to back the block up
   always begin
      if (hold_request) begin
         hold_request = 1'b0;
         rsp_pop <= 1'b0;
         repeat (LONG_HOLD) @(posedge clock);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
         rsp_pop <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      rsp_pop <= 1'b1;
      @(posedge clock);
      if (!rsp_empty) sb.compare_result(rsp_data);
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet = 0;
         else quiet++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      configure(1'b0, 32'd0);

      // literals at both extremes, longest and shortest copies, window ends, overlap
      push_beat(make_beat(8'h55, 1'b0));
      push_beat(make_beat(8'h00, 1'b0));
      send_match(12'hFEE, 4'hF);
      push_beat(make_beat(8'hFF, 1'b0));
      send_match(12'h000, 4'h0);
      push_beat(make_beat(8'hA5, 1'b0));
      send_match(12'hFFF, 4'h5);
      push_beat(make_beat(8'h5A, 1'b0));
      send_match(sb.wr_ptr - 12'd3, 4'h7);
      push_beat(make_beat(8'hFF, 1'b0));
      push_beat(make_beat(8'h80, 1'b0));
      push_beat(make_beat(8'h01, 1'b0));
      push_beat(make_beat(8'h7F, 1'b0));
      push_beat(make_beat(8'hFE, 1'b0));
      repeat (4) push_beat(make_beat(8'($urandom_range(0, 255)), 1'b0));

      drain_block();
      configure(1'b1, 32'hFFFF_FFFF);
      while (items_sent < 40) send_group();
      hold_request = 1'b1;
      while (items_sent < 90) send_group();

      drain_block();
      configure(1'b1, sb.produced + 32'($urandom_range(5000, 100000)));
      while (items_sent < 150) send_group();

      drain_block();
      calm = 1'b1;
      configure(1'b0, 32'($urandom()));
      while (items_sent < 200) send_group();

      // one way to end the stream, picked at random
      case ($urandom_range(0, 4))
         0: begin
            drain_block();
            configure(1'b1, sb.produced + 32'($urandom_range(1, 40)));
            while (!sb.done) send_group();
         end
         1: begin
            drain_block();
            configure(1'b1, 32'd0);
            push_beat(make_beat(8'($urandom_range(0, 255)), 1'b0));
         end
         2: begin
            push_beat(make_beat(8'($urandom_range(0, 255)), 1'b1));
         end
         3: begin
            drain_block();
            configure(1'b1, 32'hFFFF_FFFF);
            push_beat(make_beat(8'($urandom_range(0, 255)), 1'b1));
         end
         default: begin
            // stream cut inside a token
            push_beat(make_beat(8'($urandom_range(0, 255)), 1'b0));
            if ($urandom_range(0, 1) == 1)
               push_beat(make_beat(8'($urandom_range(0, 255)), 1'b0));
            push_beat(make_beat(8'($urandom_range(0, 255)), 1'b1));
         end
      endcase

      // once finished the block must stay silent
      drain_block();
      repeat (3) push_beat(make_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
      drain_block();

      if (sb.fails == 0 && sb.owed.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
